// File: design/tli_pkg.sv
package tli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int FREQ_W      = 33;
    localparam int GAIN_W      = 16;
    localparam int MAG_W       = GAIN_W;
    localparam int PROD_W      = FREQ_W + MAG_W;
    localparam int QUOT_W      = MAG_W;
    localparam int ENTRY_W     = FREQ_W + GAIN_W;
    localparam int STATUS_W    = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [GAIN_W-1:0] gain;
    } point_t;

endpackage

// File: design/tli_point_ram.sv
module tli_point_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [tli_pkg::IDX_W-1:0] wr_addr,
    input  tli_pkg::point_t           wr_data,
    input  logic                      rd_en,
    input  logic [tli_pkg::IDX_W-1:0] rd_addr,
    output tli_pkg::point_t           rd_data
);
    import tli_pkg::*;

    point_t mem [TABLE_DEPTH];
    point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/tli_divider.sv
module tli_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tli_pkg::PROD_W-1:0] dividend,
    input  logic [tli_pkg::FREQ_W-1:0] divisor,
    output logic                       done,
    output logic [tli_pkg::QUOT_W-1:0] quotient
);
    import tli_pkg::*;

    localparam int DEN_W  = FREQ_W + QUOT_W - 1;
    localparam int STEP_W = $clog2(QUOT_W);

    // restoring divide, quotient known to fit QUOT_W bits
    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic              fits;

    assign fits = rem_reg >= PROD_W'(den_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            den_next  = {divisor, (QUOT_W-1)'(0)};
            quot_next = '0;
            step_next = STEP_W'(QUOT_W - 1);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - PROD_W'(den_reg);
            end
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            den_next  = den_reg >> 1;
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        step_reg <= step_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// File: design/table_linear_interpolator.sv
// channel   direction  handshake                 beat
// -------   ---------  ------------------------  ---------------------------------------
// command   in         start & !busy             operation, entry_index, entry_frequency,
//                                                entry_gain, query_frequency
// config    in         cfg_valid & cfg_ready     entries_in_use
// result    out        result_valid (strobe)     gain_result, status
//
// A write leaves busy low. A query reads the point RAM one entry a cycle until the
// first point at or above the frequency or the last entry in use; if the frequency
// lies between two points it then takes the differences, the multiply, starts the
// bit-serial divider and waits for it. No command is taken while busy.
// The result strobe comes with the cycle busy falls. The receiver cannot stall.
// Reset clears control state only; the point RAM is undefined until written.
module table_linear_interpolator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [tli_pkg::IDX_W-1:0]    entry_index,
    input  logic [tli_pkg::FREQ_W-1:0]   entry_frequency,
    input  logic signed [tli_pkg::GAIN_W-1:0] entry_gain,
    input  logic [tli_pkg::FREQ_W-1:0]   query_frequency,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tli_pkg::CNT_W-1:0]    entries_in_use,
    output logic                         result_valid,
    output logic signed [tli_pkg::GAIN_W-1:0] gain_result,
    output logic [tli_pkg::STATUS_W-1:0] status
);
    import tli_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIVS = 3'd4;
    localparam logic [2:0] S_DIVW = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    entries_reg, entries_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [FREQ_W-1:0]   x_reg, x_next;
    logic [FREQ_W-1:0]   x0_reg, x0_next;
    logic [FREQ_W-1:0]   x1_reg, x1_next;
    logic [GAIN_W-1:0]   y0_reg, y0_next;
    logic [GAIN_W-1:0]   y1_reg, y1_next;
    logic [FREQ_W-1:0]   dx_reg, dx_next;
    logic [FREQ_W-1:0]   span_reg, span_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                res_valid_reg, res_valid_next;
    logic [GAIN_W-1:0]   res_gain_reg, res_gain_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic [CNT_W-1:0]    count_clamp;
    logic                ram_we;
    point_t              ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    point_t              ram_rdata;
    logic                below;
    logic                last;
    logic [GAIN_W:0]     dy;
    logic [GAIN_W:0]     y_sum;
    logic                div_start;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;

    tli_point_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (entry_index),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    tli_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign ram_wdata.freq = entry_frequency;
    assign ram_wdata.gain = entry_gain;

    assign count_clamp = (entries_reg > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : entries_reg;
    assign below = ram_rdata.freq < x_reg;
    assign last  = {1'b0, pos_reg} == (count_reg - CNT_W'(1));
    assign dy    = {y1_reg[GAIN_W-1], y1_reg} - {y0_reg[GAIN_W-1], y0_reg};
    assign y_sum = neg_reg ? ({y0_reg[GAIN_W-1], y0_reg} - {1'b0, div_quot})
                           : ({y0_reg[GAIN_W-1], y0_reg} + {1'b0, div_quot});

    always_comb
    begin
        state_next      = state_reg;
        entries_next    = entries_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        x_next          = x_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        y0_next         = y0_reg;
        y1_next         = y1_reg;
        dx_next         = dx_reg;
        span_next       = span_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        res_valid_next  = 1'b0;
        res_gain_next   = res_gain_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = pos_reg;
        div_start       = 1'b0;

        if (cfg_valid)
        begin
            entries_next = entries_in_use;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        x_next     = query_frequency;
                        count_next = count_clamp;
                        if (count_clamp == '0)
                        begin
                            res_valid_next  = 1'b1;
                            res_gain_next   = '0;
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            pos_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (below)
                begin
                    if (last)
                    begin
                        res_valid_next  = 1'b1;
                        res_gain_next   = ram_rdata.gain;
                        res_status_next = ST_CLAMPED;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        x0_next   = ram_rdata.freq;
                        y0_next   = ram_rdata.gain;
                        pos_next  = pos_reg + IDX_W'(1);
                        ram_re    = 1'b1;
                        ram_raddr = pos_reg + IDX_W'(1);
                    end
                end
                else if (pos_reg == '0)
                begin
                    res_valid_next  = 1'b1;
                    res_gain_next   = ram_rdata.gain;
                    res_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
                else
                begin
                    x1_next    = ram_rdata.freq;
                    y1_next    = ram_rdata.gain;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                dx_next    = x_reg - x0_reg;
                span_next  = x1_reg - x0_reg;
                neg_next   = dy[GAIN_W];
                mag_next   = dy[GAIN_W] ? MAG_W'(-dy) : MAG_W'(dy);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(dx_reg) * PROD_W'(mag_reg);
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    res_valid_next  = 1'b1;
                    res_gain_next   = y_sum[GAIN_W-1:0];
                    res_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg      <= count_next;
        pos_reg        <= pos_next;
        x_reg          <= x_next;
        x0_reg         <= x0_next;
        x1_reg         <= x1_next;
        y0_reg         <= y0_next;
        y1_reg         <= y1_next;
        dx_reg         <= dx_next;
        span_reg       <= span_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        prod_reg       <= prod_next;
        res_gain_reg   <= res_gain_next;
        res_status_reg <= res_status_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign gain_result  = res_gain_reg;
    assign status       = res_status_reg;

endmodule

// File: design/tli_checker.sv
module tli_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         operation,
    input logic                         result_valid,
    input logic [tli_pkg::GAIN_W-1:0]   gain_result,
    input logic [tli_pkg::STATUS_W-1:0] status
);
    import tli_pkg::*;

    // a table write never makes the block busy
    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation == OP_WRITE |=> !busy)
        else $error("write beat left the block busy");

    // every query that went busy ends with a result
    a_result_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy fell without a result beat");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result beat while busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_EMPTY |-> gain_result == '0)
        else $error("empty table result with nonzero gain");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status == ST_OK || status == ST_CLAMPED || status == ST_EMPTY)
        else $error("undefined status code");

endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .result_valid (result_valid),
    .gain_result  (gain_result),
    .status       (status)
);
